// ----- hdl/fixed_point_q24_8_alu_top_defines.svh -----
// Assertion macros used by the checker file of the Q24.8 ALU.
`ifndef FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define QALU_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qalu check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define QALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qalu check failed");
`endif

// ----- hdl/qalu_pkg.sv -----
// Package with the operation codes, widths and stage records of the Q24.8 ALU.
`timescale 1ns / 1ps
`default_nettype none
package qalu_pkg;
    localparam int FRAC_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = WORD_BITS;
    localparam int NUM_BITS  = MAG_BITS + FRAC_BITS;
    localparam int PROD_BITS = 2 * MAG_BITS;
    localparam logic signed [WORD_BITS-1:0] MAX_VAL = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MIN_VAL = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_CMP = 4'd4, OP_MIN = 4'd5, OP_MAX = 4'd6, OP_INC = 4'd7,
        OP_DEC = 4'd8, OP_FROM_INT = 4'd9, OP_TO_INT = 4'd10
    } op_t;

    typedef struct packed {
        logic                        lt;
        logic                        eq;
        logic                        gt;
        logic                        dz;
        logic                        neg;
        logic [3:0]                  op;
        logic signed [WORD_BITS-1:0] simple;
        logic                        simple_ovf;
    } side_t;

    // Saturates a wide magnitude with a separate sign to the word, returning overflow in the top bit.
    function automatic logic [WORD_BITS:0] sat_mag(input logic [NUM_BITS:0] m, input logic neg);
        logic [NUM_BITS+1:0] lim;
        logic [NUM_BITS+1:0] mm;
        begin
            lim = neg ? (NUM_BITS+2)'(1) << (WORD_BITS-1)
                      : ((NUM_BITS+2)'(1) << (WORD_BITS-1)) - 1'b1;
            mm = {1'b0, m};
            if (mm > lim)
            begin
                sat_mag = {1'b1, neg ? MIN_VAL : MAX_VAL};
            end
            else
            begin
                sat_mag = {1'b0, neg ? WORD_BITS'(-mm) : WORD_BITS'(mm)};
            end
        end
    endfunction
endpackage
`default_nettype wire

// ----- hdl/fixed_point_q24_8_alu_top.sv -----
// Top level of the pipelined signed Q24.8 fixed-point ALU.
//
//   Channel   Direction   Payload
//   s_axis    in          tdata: req_type[3:0], operand_a[35:4], operand_b[67:36]
//   m_axis    out         tdata: result_raw[31:0], a_less, a_equal, a_greater,
//                         overflow, div_zero [36:32]
//
// One transaction enters every cycle while the pipe is not stalled. The pipe has one
// input stage, forty divider stages that also carry the registered multiplier result,
// and three output stages for rounding, saturation and selection.
// rst_n clears every valid bit asynchronously; payload registers are not reset.
// The whole pipe advances only when the output register is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_top
    import qalu_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [71:0]  s_axis_tdata,   // req_type, operand_a, operand_b, zero fill
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // result_raw, less, equal, greater, ovf, dz, fill
);
    localparam int DEPTH = NUM_BITS + 4;

    logic en;
    logic [DEPTH-1:0] vld_reg;

    // The pipe moves when its final register is free or is being drained.
    assign en            = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Stage 0: register operands and precompute the operations that need no divider.
    logic [3:0]                  op_in;
    logic signed [WORD_BITS-1:0] a_in;
    logic signed [WORD_BITS-1:0] b_in;
    assign op_in = s_axis_tdata[3:0];
    assign a_in  = s_axis_tdata[35:4];
    assign b_in  = s_axis_tdata[67:36];

    side_t side_next;
    logic [MAG_BITS-1:0] ma, mb;
    always_comb
    begin
        logic signed [WORD_BITS:0] s;
        logic [WORD_BITS:0] st;
        logic signed [WORD_BITS+FRAC_BITS:0] sh;
        ma = a_in[WORD_BITS-1] ? MAG_BITS'(-a_in) : MAG_BITS'(a_in);
        mb = b_in[WORD_BITS-1] ? MAG_BITS'(-b_in) : MAG_BITS'(b_in);
        side_next.lt  = a_in < b_in;
        side_next.eq  = a_in == b_in;
        side_next.gt  = a_in > b_in;
        side_next.dz  = (op_in == OP_DIV) && (b_in == '0);
        side_next.neg = a_in[WORD_BITS-1] ^ b_in[WORD_BITS-1];
        side_next.op  = op_in;
        side_next.simple     = '0;
        side_next.simple_ovf = 1'b0;
        s = '0;
        st = '0;
        sh = '0;
        case (op_in)
            OP_ADD, OP_SUB, OP_INC, OP_DEC:
            begin
                if (op_in == OP_ADD)
                    s = (WORD_BITS+1)'(a_in) + (WORD_BITS+1)'(b_in);
                else if (op_in == OP_SUB)
                    s = (WORD_BITS+1)'(a_in) - (WORD_BITS+1)'(b_in);
                else if (op_in == OP_INC)
                    s = (WORD_BITS+1)'(a_in) + (WORD_BITS+1)'(1);
                else
                    s = (WORD_BITS+1)'(a_in) - (WORD_BITS+1)'(1);
                st = s;
                if (st[WORD_BITS] != st[WORD_BITS-1])
                begin
                    side_next.simple_ovf = 1'b1;
                    side_next.simple = st[WORD_BITS] ? MIN_VAL : MAX_VAL;
                end
                else
                begin
                    side_next.simple = st[WORD_BITS-1:0];
                end
            end
            OP_MIN:      side_next.simple = (a_in < b_in) ? a_in : b_in;
            OP_MAX:      side_next.simple = (a_in > b_in) ? a_in : b_in;
            OP_FROM_INT:
            begin
                sh = (WORD_BITS+FRAC_BITS+1)'(a_in) <<< FRAC_BITS;
                if (sh > (WORD_BITS+FRAC_BITS+1)'(MAX_VAL))
                begin
                    side_next.simple_ovf = 1'b1;
                    side_next.simple = MAX_VAL;
                end
                else if (sh < (WORD_BITS+FRAC_BITS+1)'(MIN_VAL))
                begin
                    side_next.simple_ovf = 1'b1;
                    side_next.simple = MIN_VAL;
                end
                else
                begin
                    side_next.simple = sh[WORD_BITS-1:0];
                end
            end
            OP_TO_INT:   side_next.simple = a_in >>> FRAC_BITS;
            default:     side_next.simple = '0;
        endcase
    end

    side_t side_reg [DEPTH];
    logic [MAG_BITS-1:0] ma_reg, mb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            ma_reg      <= ma;
            mb_reg      <= mb;
            for (int i = 1; i < DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Multiplier: registered product, then carried along in a delay line to match.
    localparam int MUL_DLY = NUM_BITS;
    logic [PROD_BITS-1:0] prod_reg [MUL_DLY];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= ma_reg * mb_reg;
            for (int i = 1; i < MUL_DLY; i++)
            begin
                prod_reg[i] <= prod_reg[i-1];
            end
        end
    end

    // Divider: numerator |a| << FRAC_BITS, divisor |b| (forced to one on zero).
    logic [NUM_BITS-1:0] quo;
    logic round_up;
    qalu_div u_div (
        .clk      (clk),
        .en       (en),
        .num      ({ma_reg, {FRAC_BITS{1'b0}}}),
        .den      ((mb_reg == '0) ? MAG_BITS'(1) : mb_reg),
        .quo      (quo),
        .round_up (round_up)
    );

    // Stage A: round the product and the quotient (both aligned at the same stage).
    // A rounded product too wide for the magnitude register is pinned to all
    // ones, which is far above either saturation limit.
    localparam int SA = NUM_BITS + 1;
    logic [PROD_BITS-1:0] mul_round;
    assign mul_round = prod_reg[MUL_DLY-1] + (PROD_BITS'(1) << (FRAC_BITS-1));

    logic [NUM_BITS:0] mul_mag_reg, div_mag_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_mag_reg <= (|mul_round[PROD_BITS-1:NUM_BITS+FRAC_BITS+1]) ? '1
                           : mul_round[NUM_BITS+FRAC_BITS:FRAC_BITS];
            div_mag_reg <= (NUM_BITS+1)'(quo) + (NUM_BITS+1)'(round_up);
        end
    end

    // Stage B: saturate with sign.
    logic [WORD_BITS:0] mul_sat_reg, div_sat_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_sat_reg <= sat_mag(mul_mag_reg, side_reg[SA].neg);
            div_sat_reg <= sat_mag(div_mag_reg, side_reg[SA].neg);
        end
    end

    // Stage C: select the result and pack the output register.
    side_t sc;
    logic [39:0] out_next;
    always_comb
    begin
        logic signed [WORD_BITS-1:0] r;
        logic ovf;
        sc = side_reg[SA+1];
        r = sc.simple;
        ovf = sc.simple_ovf;
        case (sc.op)
            OP_MUL:
            begin
                r = mul_sat_reg[WORD_BITS-1:0];
                ovf = mul_sat_reg[WORD_BITS];
            end
            OP_DIV:
            begin
                r = sc.dz ? '0 : div_sat_reg[WORD_BITS-1:0];
                ovf = sc.dz ? 1'b0 : div_sat_reg[WORD_BITS];
            end
            default: ;
        endcase
        out_next = {3'b0, sc.dz, ovf, sc.gt, sc.eq, sc.lt, r};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= out_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/qalu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with rounding remainder.
`timescale 1ns / 1ps
`default_nettype none
module qalu_div
    import qalu_pkg::*;
(
    input  wire                  clk,
    input  wire                  en,
    input  wire [NUM_BITS-1:0]   num,
    input  wire [MAG_BITS-1:0]   den,
    output logic [NUM_BITS-1:0]  quo,
    output logic                 round_up
);
    localparam int STAGES = NUM_BITS;
    logic [NUM_BITS-1:0] q_reg [STAGES+1];
    logic [MAG_BITS:0]   r_reg [STAGES+1];
    logic [MAG_BITS-1:0] d_reg [STAGES+1];

    always_comb
    begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [MAG_BITS+1:0] trial;
        logic [MAG_BITS:0]   sh;
        always_comb
        begin
            sh    = {r_reg[s][MAG_BITS-1:0], q_reg[s][NUM_BITS-1]};
            trial = {1'b0, sh} - {2'b0, d_reg[s]};
        end
        logic [NUM_BITS-1:0] qn;
        logic [MAG_BITS:0]   rn;
        always_comb
        begin
            qn = {q_reg[s][NUM_BITS-2:0], ~trial[MAG_BITS+1]};
            rn = trial[MAG_BITS+1] ? sh : trial[MAG_BITS:0];
        end
        logic [NUM_BITS-1:0] q_st;
        logic [MAG_BITS:0]   r_st;
        logic [MAG_BITS-1:0] d_st;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_st <= qn;
                r_st <= rn;
                d_st <= d_reg[s];
            end
        end
        always_comb
        begin
            q_reg[s+1] = q_st;
            r_reg[s+1] = r_st;
            d_reg[s+1] = d_st;
        end
    end

    // Round half away from zero: twice the remainder at least the divisor.
    always_comb
    begin
        quo      = q_reg[STAGES];
        round_up = ({r_reg[STAGES], 1'b0} >= {2'b0, d_reg[STAGES]});
    end
endmodule
`default_nettype wire

// ----- hdl/qalu_checker.sv -----
// Port-level checker for the Q24.8 ALU and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_q24_8_alu_top_defines.svh"
module qalu_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);
    `QALU_ASSERT(a_one_hot_cmp, m_axis_tvalid, $onehot(m_axis_tdata[34:32]))
    `QALU_ASSERT(a_dz_no_ovf, m_axis_tvalid && m_axis_tdata[36], !m_axis_tdata[35])
    `QALU_ASSERT(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
    `QALU_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind fixed_point_q24_8_alu_top qalu_checker u_qalu_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
